@@ sv/ssi_pkg.sv @@
// Shared constants, types and codes for the segment intersection block.
package ssi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 32;

    localparam int DFW  = COORD_BITS + 1;        // coordinate difference
    localparam int PW   = 2 * DFW;               // product of two differences
    localparam int DETW = PW + 1;                // det and numerators, signed
    localparam int DW   = DETW - 1;              // magnitude of det, remainder
    localparam int NW   = DW + COORD_BITS;       // numerator times |delta|
    localparam int QW   = COORD_BITS + FRAC_BITS; // quotient bits
    localparam int SW   = QW + 2;                // final sum

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

    typedef struct packed {
        t_status                        status;
        logic                           neg_x;
        logic                           neg_y;
        logic signed [COORD_BITS-1:0]   base_x;
        logic signed [COORD_BITS-1:0]   base_y;
        logic [NW-1:0]                  num_x;
        logic [NW-1:0]                  num_y;
        logic [DW-1:0]                  det;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_if;

endpackage

@@ sv/segment_segment_intersection.sv @@
// Top level of the two-segment intersection block.
// Takes one item per clock: an item is accepted when i_start is high and o_busy is low, and
// its result appears on o_status, o_point_x and o_point_y for one cycle with o_valid high,
// after the 5 front stages, the queue register, the divider's load stage, its 32 steps and the output
// register. The receiver cannot stall; o_busy only rises if the queue between the front
// and the divider fills, which a free-running divider keeps from happening. status 0 is a
// hit with the point in signed fixed point, 16 fraction bits, rounded toward minus
// infinity; 1 is parallel or degenerate and 2 is a crossing outside either segment, both
// with a zero point. The pipelined divider, one quotient bit per stage, sets the latency.
module segment_segment_intersection (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_first_start_x,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_first_start_y,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_first_end_x,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_first_end_y,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_second_start_x,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_second_start_y,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_second_end_x,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_second_end_y,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output logic signed [ssi_pkg::OUT_BITS-1:0]   o_point_x,
    output logic signed [ssi_pkg::OUT_BITS-1:0]   o_point_y
);
    ssi_pkg::t_job_if front_job, queue_job;
    logic             queue_full;

    assign o_busy = queue_full;

    ssi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_start && !o_busy),
        .i_x1     (i_first_start_x),
        .i_y1     (i_first_start_y),
        .i_x2     (i_first_end_x),
        .i_y2     (i_first_end_y),
        .i_x3     (i_second_start_x),
        .i_y3     (i_second_start_y),
        .i_x4     (i_second_end_x),
        .i_y4     (i_second_end_y),
        .o_job    (front_job)
    );

    ssi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (front_job),
        .o_job   (queue_job),
        .o_full  (queue_full)
    );

    ssi_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (queue_job),
        .o_valid   (o_valid),
        .o_status  (o_status),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y)
    );

endmodule

@@ sv/ssi_front.sv @@
// Front pipeline: forms the 2x2 system, classifies the item and builds the division job.
module ssi_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  logic signed [ssi_pkg::COORD_BITS-1:0]  i_x1,
    input  logic signed [ssi_pkg::COORD_BITS-1:0]  i_y1,
    input  logic signed [ssi_pkg::COORD_BITS-1:0]  i_x2,
    input  logic signed [ssi_pkg::COORD_BITS-1:0]  i_y2,
    input  logic signed [ssi_pkg::COORD_BITS-1:0]  i_x3,
    input  logic signed [ssi_pkg::COORD_BITS-1:0]  i_y3,
    input  logic signed [ssi_pkg::COORD_BITS-1:0]  i_x4,
    input  logic signed [ssi_pkg::COORD_BITS-1:0]  i_y4,
    output ssi_pkg::t_job_if                       o_job
);
    localparam int C    = ssi_pkg::COORD_BITS;
    localparam int DFW  = ssi_pkg::DFW;
    localparam int PW   = ssi_pkg::PW;
    localparam int DETW = ssi_pkg::DETW;
    localparam int DW   = ssi_pkg::DW;
    localparam int NW   = ssi_pkg::NW;

    logic [5:1] r_v;

    // stage 1: differences
    logic signed [DFW-1:0] r_a, r_b, r_c, r_d, r_f, r_g;
    logic signed [C-1:0]   r1_x1, r1_y1;
    // stage 2: products
    logic signed [PW-1:0]  r_ad, r_bc, r_fd, r_bg, r_ag, r_fc;
    logic signed [C-1:0]   r2_x1, r2_y1;
    logic [C-1:0]          r2_am, r2_cm;
    logic                  r2_sa, r2_sc;
    // stage 3: det and numerators
    logic signed [DETW-1:0] r_det, r_nt, r_nu;
    logic signed [C-1:0]   r3_x1, r3_y1;
    logic [C-1:0]          r3_am, r3_cm;
    logic                  r3_sa, r3_sc;
    // stage 4: classification and magnitudes
    ssi_pkg::t_status      r4_st;
    logic [DW-1:0]         r4_ntm, r4_detm;
    logic signed [C-1:0]   r4_x1, r4_y1;
    logic [C-1:0]          r4_am, r4_cm;
    logic                  r4_sa, r4_sc;
    // stage 5: job
    ssi_pkg::t_job         r5_job;

    logic                  n_pos, n_tin, n_uin;
    ssi_pkg::t_status      n_st;

    always_comb begin
        n_pos = !r_det[DETW-1];
        if (n_pos) begin
            n_tin = (r_nt >= 0) && (r_nt <= r_det);
            n_uin = (r_nu >= 0) && (r_nu <= r_det);
        end else begin
            n_tin = (r_nt <= 0) && (r_nt >= r_det);
            n_uin = (r_nu <= 0) && (r_nu >= r_det);
        end
        if (r_det == '0)
            n_st = ssi_pkg::ST_PARALLEL;
        else if (!(n_tin && n_uin))
            n_st = ssi_pkg::ST_OUTSIDE;
        else
            n_st = ssi_pkg::ST_HIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:1], i_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= DFW'(i_x2) - DFW'(i_x1);
        r_b   <= DFW'(i_x3) - DFW'(i_x4);
        r_c   <= DFW'(i_y2) - DFW'(i_y1);
        r_d   <= DFW'(i_y3) - DFW'(i_y4);
        r_f   <= DFW'(i_x3) - DFW'(i_x1);
        r_g   <= DFW'(i_y3) - DFW'(i_y1);
        r1_x1 <= i_x1;
        r1_y1 <= i_y1;

        r_ad  <= r_a * r_d;
        r_bc  <= r_b * r_c;
        r_fd  <= r_f * r_d;
        r_bg  <= r_b * r_g;
        r_ag  <= r_a * r_g;
        r_fc  <= r_f * r_c;
        r2_am <= C'(r_a[DFW-1] ? -r_a : r_a);
        r2_cm <= C'(r_c[DFW-1] ? -r_c : r_c);
        r2_sa <= r_a[DFW-1];
        r2_sc <= r_c[DFW-1];
        r2_x1 <= r1_x1;
        r2_y1 <= r1_y1;

        r_det <= DETW'(r_ad) - DETW'(r_bc);
        r_nt  <= DETW'(r_fd) - DETW'(r_bg);
        r_nu  <= DETW'(r_ag) - DETW'(r_fc);
        r3_am <= r2_am;
        r3_cm <= r2_cm;
        r3_sa <= r2_sa;
        r3_sc <= r2_sc;
        r3_x1 <= r2_x1;
        r3_y1 <= r2_y1;

        // normalize to a positive det; only hits use the magnitudes
        r4_st   <= n_st;
        r4_ntm  <= DW'(n_pos ? r_nt : -r_nt);
        r4_detm <= DW'(n_pos ? r_det : -r_det);
        r4_am   <= r3_am;
        r4_cm   <= r3_cm;
        r4_sa   <= r3_sa;
        r4_sc   <= r3_sc;
        r4_x1   <= r3_x1;
        r4_y1   <= r3_y1;

        r5_job.status <= r4_st;
        r5_job.neg_x  <= r4_sa;
        r5_job.neg_y  <= r4_sc;
        r5_job.base_x <= r4_x1;
        r5_job.base_y <= r4_y1;
        r5_job.num_x  <= NW'(r4_ntm) * NW'(r4_am);
        r5_job.num_y  <= NW'(r4_ntm) * NW'(r4_cm);
        r5_job.det    <= r4_detm;
    end

    assign o_job.valid = r_v[5];
    assign o_job.job   = r5_job;

endmodule

@@ sv/ssi_queue.sv @@
// Two-entry queue between the front pipeline and the divider pipeline.
module ssi_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ssi_pkg::t_job_if i_job,
    output ssi_pkg::t_job_if o_job,
    output logic             o_full
);
    ssi_pkg::t_job r_mem [0:1];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          n_pop;

    assign n_pop = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_job.valid) r_wp <= ~r_wp;
            if (n_pop)       r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_job.valid) - 2'(n_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.valid) r_mem[r_wp] <= i_job.job;
    end

    // the divider pipeline never stalls: pop whenever an item waits
    assign o_job.valid = n_pop;
    assign o_job.job   = r_mem[r_rp];
    assign o_full      = (r_cnt == 2'd2);

endmodule

@@ sv/ssi_back.sv @@
// Back pipeline: one restoring division step per stage for x and y, then the final point.
module ssi_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ssi_pkg::t_job_if                      i_job,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output logic signed [ssi_pkg::OUT_BITS-1:0]   o_point_x,
    output logic signed [ssi_pkg::OUT_BITS-1:0]   o_point_y
);
    localparam int C  = ssi_pkg::COORD_BITS;
    localparam int F  = ssi_pkg::FRAC_BITS;
    localparam int DW = ssi_pkg::DW;
    localparam int QW = ssi_pkg::QW;
    localparam int SW = ssi_pkg::SW;
    localparam int OW = ssi_pkg::OUT_BITS;

    typedef struct packed {
        ssi_pkg::t_status      status;
        logic                  neg_x;
        logic                  neg_y;
        logic signed [C-1:0]   base_x;
        logic signed [C-1:0]   base_y;
        logic [DW-1:0]         det;
    } t_side;

    logic          r_v    [0:QW];
    t_side         r_side [0:QW];
    logic [DW-1:0] r_rx   [0:QW];
    logic [DW-1:0] r_ry   [0:QW];
    logic [QW-1:0] r_lx   [0:QW];
    logic [QW-1:0] r_ly   [0:QW];
    logic [QW-1:0] r_qx   [0:QW];
    logic [QW-1:0] r_qy   [0:QW];

    // stage 0: quotient is known to fit QW bits, so start with the top of the dividend
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_job.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0].status <= i_job.job.status;
        r_side[0].neg_x  <= i_job.job.neg_x;
        r_side[0].neg_y  <= i_job.job.neg_y;
        r_side[0].base_x <= i_job.job.base_x;
        r_side[0].base_y <= i_job.job.base_y;
        r_side[0].det    <= i_job.job.det;
        r_rx[0] <= DW'(i_job.job.num_x >> C);
        r_ry[0] <= DW'(i_job.job.num_y >> C);
        r_lx[0] <= QW'(i_job.job.num_x[C-1:0]) << F;
        r_ly[0] <= QW'(i_job.job.num_y[C-1:0]) << F;
        r_qx[0] <= '0;
        r_qy[0] <= '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] n_cx, n_cy;
        logic        n_bx, n_by;

        always_comb begin
            n_cx = {r_rx[k], r_lx[k][QW-1]};
            n_cy = {r_ry[k], r_ly[k][QW-1]};
            n_bx = (n_cx >= {1'b0, r_side[k].det});
            n_by = (n_cy >= {1'b0, r_side[k].det});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k+1] <= r_side[k];
            r_rx[k+1]   <= DW'(n_bx ? n_cx - {1'b0, r_side[k].det} : n_cx);
            r_ry[k+1]   <= DW'(n_by ? n_cy - {1'b0, r_side[k].det} : n_cy);
            r_lx[k+1]   <= r_lx[k] << 1;
            r_ly[k+1]   <= r_ly[k] << 1;
            r_qx[k+1]   <= {r_qx[k][QW-2:0], n_bx};
            r_qy[k+1]   <= {r_qy[k][QW-2:0], n_by};
        end
    end

    // floor of a negative quotient: -q, one lower when a remainder is left
    logic signed [SW-1:0] n_bx_s, n_by_s, n_ax, n_ay, n_px, n_py;
    logic                 n_hit;

    always_comb begin
        n_bx_s = SW'(r_side[QW].base_x) <<< F;
        n_by_s = SW'(r_side[QW].base_y) <<< F;
        n_ax   = r_side[QW].neg_x ? (~SW'(r_qx[QW])) + SW'(r_rx[QW] == '0) : SW'(r_qx[QW]);
        n_ay   = r_side[QW].neg_y ? (~SW'(r_qy[QW])) + SW'(r_ry[QW] == '0) : SW'(r_qy[QW]);
        n_px   = n_bx_s + n_ax;
        n_py   = n_by_s + n_ay;
        n_hit  = (r_side[QW].status == ssi_pkg::ST_HIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        o_status  <= r_side[QW].status;
        o_point_x <= n_hit ? OW'(n_px) : '0;
        o_point_y <= n_hit ? OW'(n_py) : '0;
    end

endmodule
